/* rtl/core/xsb_pkg.sv */
// Shared constants and codes of the XOR sprite blitter.
`timescale 1ns / 1ps
`default_nettype none

package xsb_pkg;

  localparam int STRIDE_BYTES = 32;
  localparam int LINES        = 256;
  localparam int STORE_SIZE   = STRIDE_BYTES * LINES;
  localparam int STORE_AW     = $clog2(STORE_SIZE);

  // Largest base+1 is 31 + 31 + STRIDE_BYTES * 510 + 1.
  localparam int BASE_W = $clog2(STRIDE_BYTES * 510 + 64);

  localparam int PIX_W  = 8;
  localparam int COL_W  = 5;
  localparam int RADDR_W = 13;

  localparam logic ACT_DRAW = 1'b0;
  localparam logic ACT_READ = 1'b1;

endpackage

`default_nettype wire

/* rtl/core/xsb_if.sv */
// Valid/ready channel interfaces for draw/read items and read results.
`timescale 1ns / 1ps
`default_nettype none

interface xsb_cmd_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [xsb_pkg::PIX_W-1:0]     origin_x;
  logic [xsb_pkg::PIX_W-1:0]     origin_y;
  logic [xsb_pkg::PIX_W-1:0]     sprite_row;
  logic [xsb_pkg::COL_W-1:0]     sprite_col;
  logic [xsb_pkg::PIX_W-1:0]     sprite_byte;
  logic [xsb_pkg::RADDR_W-1:0]   read_address;

  modport source (
    output valid, action, origin_x, origin_y, sprite_row, sprite_col, sprite_byte,
           read_address,
    input  ready
  );
  modport sink (
    input  valid, action, origin_x, origin_y, sprite_row, sprite_col, sprite_byte,
           read_address,
    output ready
  );
endinterface

interface xsb_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [xsb_pkg::PIX_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

`default_nettype wire

/* rtl/core/xsb_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module xsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/xor_sprite_blitter.sv */
// Top level of the XOR sprite blitter: sequencer around a one-bit-per-pixel frame RAM.
//
// Items arrive on the cmd channel and results leave on the rsp channel, both
// valid/ready. A draw item XORs one sprite byte into the frame at any pixel x,
// touching one byte when x is a multiple of eight and two adjacent bytes
// otherwise; it gives no result. A read item gives one result with the stored
// byte, or zero when the address lies past the end of the frame.
// A draw makes one read-modify-write pass through the single frame RAM write
// port for each touched byte, in state ST_X0 and, for an unaligned x, ST_X1.
// A read reads the frame RAM on accept; in ST_RD its result is loaded into the
// output register once that register is free, and is offered from the
// following cycle on.
// The output register parts the two sides: new items are accepted while a
// result waits, but a read item that finds the register still full holds in
// the sequencer until the receiver takes the earlier result.
// After reset the frame RAM is cleared one byte a cycle, all 8192 bytes;
// cmd.ready stays low during that pass and no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module xor_sprite_blitter (
  input wire logic clk,
  input wire logic rst,
  xsb_cmd_if.sink   cmd,
  xsb_rsp_if.source rsp
);

  localparam int AW = xsb_pkg::STORE_AW;
  localparam int BW = xsb_pkg::BASE_W;
  localparam int RW = xsb_pkg::RADDR_W;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_X0    = 5'b00100,
    ST_X1    = 5'b01000,
    ST_RD    = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [AW-1:0] clr_addr;

  logic [BW-1:0]                addr0;
  logic [BW-1:0]                addr1;
  logic [xsb_pkg::PIX_W-1:0]    bits0;
  logic [xsb_pkg::PIX_W-1:0]    bits1;
  logic                         shift_nz;
  logic                         rd_ok;

  logic                         out_valid;
  logic [xsb_pkg::PIX_W-1:0]    out_data;

  logic [BW-1:0]                base_in;
  logic [2*xsb_pkg::PIX_W-1:0]  spread;
  logic                         accept;
  logic                         out_free;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [xsb_pkg::PIX_W-1:0]    ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [xsb_pkg::PIX_W-1:0]    ram_rdata;

  assign cmd.ready     = (state == ST_IDLE);
  assign accept        = cmd.valid && cmd.ready;
  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;
  assign out_free      = !out_valid || rsp.ready;

  assign base_in = BW'(cmd.origin_x >> 3) + BW'(cmd.sprite_col)
                 + BW'(xsb_pkg::STRIDE_BYTES) * (BW'(cmd.origin_y) + BW'(cmd.sprite_row));

  // The sprite byte shifted across a 16-bit window: high half lands at base,
  // low half at base+1.
  assign spread = {cmd.sprite_byte, 8'h00} >> cmd.origin_x[2:0];

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = AW'(base_in);
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr == AW'(xsb_pkg::STORE_SIZE - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          ram_re = 1'b1;
          if (cmd.action == xsb_pkg::ACT_READ) begin
            ram_raddr  = AW'(cmd.read_address);
            state_next = ST_RD;
          end else begin
            state_next = ST_X0;
          end
        end
      end
      ST_X0: begin
        ram_we    = (addr0 < BW'(xsb_pkg::STORE_SIZE));
        ram_waddr = AW'(addr0);
        ram_wdata = ram_rdata ^ bits0;
        if (shift_nz) begin
          ram_re     = 1'b1;
          ram_raddr  = AW'(addr1);
          state_next = ST_X1;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_X1: begin
        ram_we     = (addr1 < BW'(xsb_pkg::STORE_SIZE));
        ram_waddr  = AW'(addr1);
        ram_wdata  = ram_rdata ^ bits1;
        state_next = ST_IDLE;
      end
      ST_RD: begin
        // Read data holds in the RAM output register until the result slot frees.
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == ST_RD && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr0    <= base_in;
      addr1    <= base_in + BW'(1);
      bits0    <= spread[2*xsb_pkg::PIX_W-1:xsb_pkg::PIX_W];
      bits1    <= spread[xsb_pkg::PIX_W-1:0];
      shift_nz <= (cmd.origin_x[2:0] != 3'd0);
      rd_ok    <= ({1'b0, cmd.read_address} < (RW + 1)'(xsb_pkg::STORE_SIZE));
    end
    if (state == ST_RD && out_free) begin
      out_data <= rd_ok ? ram_rdata : '0;
    end
  end

  xsb_ram #(
    .WIDTH (xsb_pkg::PIX_W),
    .DEPTH (xsb_pkg::STORE_SIZE)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

/* dv/tb_xor_sprite_blitter.sv */
// Self-checking testbench for the XOR sprite blitter: random draw and read items against a frame predictor.
`timescale 1ns / 1ps

module tb_xor_sprite_blitter;

  localparam int PIX_W        = xsb_pkg::PIX_W;
  localparam int COL_W        = xsb_pkg::COL_W;
  localparam int RADDR_W      = xsb_pkg::RADDR_W;
  localparam int STORE_SIZE   = xsb_pkg::STORE_SIZE;
  localparam int STRIDE_BYTES = xsb_pkg::STRIDE_BYTES;

  localparam int ITEM_TARGET  = 650;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 10;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct packed {
    logic                 action;
    logic [PIX_W-1:0]     origin_x;
    logic [PIX_W-1:0]     origin_y;
    logic [PIX_W-1:0]     sprite_row;
    logic [COL_W-1:0]     sprite_col;
    logic [PIX_W-1:0]     sprite_byte;
    logic [RADDR_W-1:0]   read_address;
  } blit_item_t;

  // Keeps its own copy of the frame and the read data that is still owed.
  class frame_scoreboard;
    bit   [PIX_W-1:0] frame_bytes [STORE_SIZE];
    logic [PIX_W-1:0] expected_reads [$];
    int               errors;

    function void xor_byte(int addr, logic [PIX_W-1:0] bits);
      if (addr < STORE_SIZE) frame_bytes[addr] ^= bits;
    endfunction

    function void note_item(blit_item_t item);
      int         base;
      logic [2:0] shift;
      if (item.action == xsb_pkg::ACT_READ) begin
        expected_reads.push_back((int'(item.read_address) < STORE_SIZE) ?
                                 frame_bytes[item.read_address] : '0);
        return;
      end
      shift = item.origin_x[2:0];
      base  = int'(item.origin_x >> 3) + int'(item.sprite_col) +
              STRIDE_BYTES * (int'(item.origin_y) + int'(item.sprite_row));
      xor_byte(base, item.sprite_byte >> shift);
      // The spill goes to the next linear byte, which may start the next line.
      if (shift != 3'd0) xor_byte(base + 1, item.sprite_byte << (4'd8 - shift));
    endfunction

    function void check_result(logic [PIX_W-1:0] got);
      logic [PIX_W-1:0] want;
      if (expected_reads.size() == 0) begin
        $error("read_data: expected no item, actual %02h", got);
        errors++;
        return;
      end
      want = expected_reads.pop_front();
      if (got !== want) begin
        $error("read_data: expected %02h, actual %02h", want, got);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_reads.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  xsb_cmd_if cmd_ch ();
  xsb_rsp_if rsp_ch ();

  xor_sprite_blitter dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  frame_scoreboard sb;
  int items_sent;
  int last_base;
  int cycle_count;
  bit calm_phase;
  bit hold_off_req;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, none at all in a calm phase.
  function automatic int idle_gap();
    int pick;
    if (calm_phase) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic blit_item_t draw_item(logic [7:0] x, logic [7:0] y, logic [7:0] row,
                                           logic [COL_W-1:0] col, logic [7:0] data);
    blit_item_t item;
    item.action       = xsb_pkg::ACT_DRAW;
    item.origin_x     = x;
    item.origin_y     = y;
    item.sprite_row   = row;
    item.sprite_col   = col;
    item.sprite_byte  = data;
    item.read_address = RADDR_W'($urandom);
    return item;
  endfunction

  function automatic blit_item_t random_draw();
    return draw_item(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                     COL_W'($urandom), PIX_W'($urandom));
  endfunction

  // Draw fields carry noise on a read; the block must ignore them.
  function automatic blit_item_t read_item(logic [RADDR_W-1:0] addr);
    blit_item_t item;
    item = random_draw();
    item.action       = xsb_pkg::ACT_READ;
    item.read_address = addr;
    return item;
  endfunction

  task automatic send_item(input blit_item_t item);
    int gap;
    cmd_ch.valid        <= 1'b1;
    cmd_ch.action       <= item.action;
    cmd_ch.origin_x     <= item.origin_x;
    cmd_ch.origin_y     <= item.origin_y;
    cmd_ch.sprite_row   <= item.sprite_row;
    cmd_ch.sprite_col   <= item.sprite_col;
    cmd_ch.sprite_byte  <= item.sprite_byte;
    cmd_ch.read_address <= item.read_address;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sb.note_item(item);
    items_sent++;
    @(negedge clk);
    gap = idle_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_results_done();
    cmd_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // A small sprite drawn row by row, sometimes drawn twice to erase it, then read back.
  task automatic draw_sprite();
    int         h;
    int         w;
    int         r;
    int         c;
    int         pass;
    int         passes;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] pix [6][3];
    h = $urandom_range(1, 6);
    w = $urandom_range(1, 3);
    x = PIX_W'($urandom);
    y = PIX_W'($urandom);
    passes = ($urandom_range(0, 3) == 0) ? 2 : 1;
    for (r = 0; r < h; r++)
      for (c = 0; c < w; c++)
        pix[r][c] = PIX_W'($urandom);
    for (pass = 0; pass < passes; pass++)
      for (r = 0; r < h; r++)
        for (c = 0; c < w; c++)
          send_item(draw_item(x, y, PIX_W'(r), COL_W'(c), pix[r][c]));
    last_base = int'(x >> 3) + STRIDE_BYTES * int'(y);
    for (r = 0; r < h; r++)
      send_item(read_item(RADDR_W'(last_base + STRIDE_BYTES * r + $urandom_range(0, w))));
  endtask

  task automatic random_items(input int stop_at);
    int pick;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        draw_sprite();
      end else if (pick < 60) begin
        send_item(read_item(RADDR_W'($urandom)));
      end else if (pick < 75) begin
        send_item(read_item(RADDR_W'(last_base + $urandom_range(0, 3 * STRIDE_BYTES))));
      end else begin
        send_item(random_draw());
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.read_data);
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int gap;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        rsp_ch.ready <= 1'b0;
        hold_off_req = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        gap = idle_gap();
        if (gap == 0) begin
          rsp_ch.ready <= 1'b1;
          @(negedge clk);
        end else begin
          rsp_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  end

  // The limit covers the frame clear after reset many times over.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[xor_sprite_blitter] ERROR");
    $finish;
  end

  initial begin
    int k;
    sb = new;
    items_sent   = 0;
    last_base    = 0;
    calm_phase   = 1'b0;
    hold_off_req = 1'b0;
    rst                 = 1'b1;
    cmd_ch.valid        = 1'b0;
    cmd_ch.action       = xsb_pkg::ACT_DRAW;
    cmd_ch.origin_x     = '0;
    cmd_ch.origin_y     = '0;
    cmd_ch.sprite_row   = '0;
    cmd_ch.sprite_col   = '0;
    cmd_ch.sprite_byte  = '0;
    cmd_ch.read_address = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: corners of the frame, line-end spill, dropped writes, XOR erase.
    send_item(read_item(13'd0));
    send_item(draw_item(8'd0, 8'd0, 8'd0, 5'd0, 8'hFF));
    send_item(read_item(13'd0));
    send_item(draw_item(8'd7, 8'd0, 8'd0, 5'd31, 8'hA5));
    send_item(read_item(13'd31));
    send_item(read_item(13'd32));
    send_item(draw_item(8'd255, 8'd255, 8'd255, 5'd31, 8'hFF));
    send_item(draw_item(8'd251, 8'd255, 8'd0, 5'd0, 8'hFF));
    send_item(read_item(13'h1FFF));
    send_item(draw_item(8'd250, 8'd254, 8'd1, 5'd0, 8'h81));
    send_item(read_item(13'h1FFF));
    send_item(draw_item(8'd3, 8'd10, 8'd20, 5'd5, 8'h00));
    send_item(draw_item(8'd0, 8'd0, 8'd0, 5'd0, 8'hFF));
    send_item(read_item(13'd0));
    send_item(draw_item(8'd8, 8'd1, 8'd2, 5'd1, 8'h80));
    send_item(draw_item(8'd9, 8'd1, 8'd2, 5'd1, 8'h80));
    send_item(read_item(13'd98));
    send_item(read_item(13'd99));
    send_item(draw_item(8'd4, 8'd0, 8'd255, 5'd0, 8'h3C));
    send_item(read_item(13'd8160));
    send_item(read_item(13'd8161));
    wait_results_done();

    random_items(260);

    // Hold the result side off while reads keep coming, so the block backs up.
    calm_phase   = 1'b1;
    hold_off_req = 1'b1;
    for (k = 0; k < 12; k++) send_item(read_item(RADDR_W'($urandom)));
    calm_phase = 1'b0;
    wait_results_done();

    calm_phase = 1'b1;
    random_items(420);
    calm_phase = 1'b0;
    random_items(ITEM_TARGET);

    wait_results_done();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("[xor_sprite_blitter] OK");
    end else begin
      $display("[xor_sprite_blitter] ERROR");
    end
    $finish;
  end

endmodule
